// ===== hdl/rlcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcs_pkg
// types, constants and helpers shared by the rgb led current scaler
// ----------------------------------------------------------------------------
package rlcs_pkg;

    localparam int NUM_LEDS_DEF = 4;
    localparam int JOBQ_DEPTH   = 2;
    localparam int JOBQ_PTR_W   = $clog2(JOBQ_DEPTH);
    localparam int CFG_IDX_W    = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RED_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LIMIT  = 2'd2;

    localparam logic [7:0] RED_LIMIT_RST   = 8'h5c;
    localparam logic [7:0] GREEN_LIMIT_RST = 8'h38;
    localparam logic [7:0] BLUE_LIMIT_RST  = 8'h67;
    localparam logic [7:0] BRIGHTNESS_RST  = 8'd255;

    localparam logic [4:0] BASE_EVEN = 5'h15;
    localparam logic [4:0] BASE_ODD  = 5'h18;

    // item kinds
    localparam logic KIND_COLOR  = 1'b0;
    localparam logic KIND_BRIGHT = 1'b1;

    // write steps within one led: blue, red, green
    localparam logic [1:0] STEP_BLUE  = 2'd0;
    localparam logic [1:0] STEP_RED   = 2'd1;
    localparam logic [1:0] STEP_GREEN = 2'd2;

    // color store offsets within one led
    localparam logic [1:0] OFS_RED   = 2'd0;
    localparam logic [1:0] OFS_GREEN = 2'd1;
    localparam logic [1:0] OFS_BLUE  = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [1:0] led_index;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [7:0] new_brightness;
    } item_t;

    typedef struct packed {
        logic       controller_sel;
        logic [4:0] register_addr;
        logic [7:0] current_code;
        logic       last_write;
    } result_t;

    typedef struct packed {
        logic       is_bright;
        logic [1:0] led;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] brightness;
    } job_t;

    typedef struct packed {
        logic [7:0] red_limit;
        logic [7:0] green_limit;
        logic [7:0] blue_limit;
    } limits_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_EMIT
    } state_t;

    // exact floor(x / 255) for x up to 255 * 255, where the result fits in 8 bits
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ===== hdl/rlcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcs_front
// takes input requests, drops out-of-range leds, builds queue jobs
// ----------------------------------------------------------------------------
module rlcs_front #(
    parameter int NUM_LEDS = rlcs_pkg::NUM_LEDS_DEF
) (
    input  logic            push,
    input  rlcs_pkg::item_t item,
    input  logic            q_full,
    output logic            full,
    output logic            job_push,
    output rlcs_pkg::job_t  job
);
    import rlcs_pkg::*;

    logic led_ok;

    assign full   = q_full;
    assign led_ok = (int'(item.led_index) < NUM_LEDS);

    // brightness requests go through whenever the queue has room, color requests only for real leds
    assign job_push = push && !q_full && ((item.kind == KIND_BRIGHT) || led_ok);

    always_comb
    begin
        job.is_bright  = (item.kind == KIND_BRIGHT);
        job.led        = item.led_index;
        job.red        = item.red_level;
        job.green      = item.green_level;
        job.blue       = item.blue_level;
        job.brightness = item.new_brightness;
    end

endmodule

// ===== hdl/rlcs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcs_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module rlcs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  rlcs_pkg::job_t wr_job,
    input  logic           rd_en,
    output rlcs_pkg::job_t rd_job,
    output logic           q_full,
    output logic           q_valid
);
    import rlcs_pkg::*;

    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

    job_t                  slots_reg [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] wr_ptr_reg;
    logic [JOBQ_PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;

    assign q_full  = (count_reg == CNT_W'(JOBQ_DEPTH));
    assign q_valid = (count_reg != '0);
    assign rd_job  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == JOBQ_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == JOBQ_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/rlcs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcs_back
// applies jobs to led state and emits scaled register writes
// ----------------------------------------------------------------------------
module rlcs_back #(
    parameter int NUM_LEDS = rlcs_pkg::NUM_LEDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rlcs_pkg::job_t    job,
    input  logic              job_valid,
    output logic              job_pop,
    input  rlcs_pkg::limits_t limits,
    output rlcs_pkg::result_t result,
    output logic              empty,
    input  logic              pop
);
    import rlcs_pkg::*;

    localparam int NUM_ENT = NUM_LEDS * 3;
    localparam int CIDX_W  = $clog2(NUM_ENT);

    state_t      state_reg, state_next;
    logic [7:0]  colors_reg [NUM_ENT];
    logic [7:0]  colors_next [NUM_ENT];
    logic [7:0]  bright_reg, bright_next;
    logic [1:0]  led_reg, led_next;
    logic [1:0]  last_led_reg, last_led_next;
    logic [1:0]  step_reg, step_next;
    logic [15:0] prod1_reg, prod1_next;
    logic [15:0] prod2_reg, prod2_next;
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic [1:0]        ofs;
    logic [CIDX_W-1:0] color_idx;
    logic [7:0]        color_rd;
    logic [7:0]        limit_sel;
    logic              is_last;

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    always_comb
    begin
        case (step_reg)
            STEP_BLUE:  begin ofs = OFS_BLUE;  limit_sel = limits.blue_limit;  end
            STEP_RED:   begin ofs = OFS_RED;   limit_sel = limits.red_limit;   end
            STEP_GREEN: begin ofs = OFS_GREEN; limit_sel = limits.green_limit; end
            default:    begin ofs = OFS_BLUE;  limit_sel = limits.blue_limit;  end
        endcase
    end

    assign color_idx = CIDX_W'(int'(led_reg) * 3 + int'(ofs));
    assign color_rd  = colors_reg[color_idx];
    assign is_last   = (step_reg == STEP_GREEN) && (led_reg == last_led_reg);

    always_comb
    begin
        state_next     = state_reg;
        colors_next    = colors_reg;
        bright_next    = bright_reg;
        led_next       = led_reg;
        last_led_next  = last_led_reg;
        step_next      = step_reg;
        prod1_next     = prod1_reg;
        prod2_next     = prod2_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        job_pop        = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    step_next = STEP_BLUE;
                    if (job.is_bright)
                    begin
                        bright_next   = job.brightness;
                        led_next      = '0;
                        last_led_next = 2'(NUM_LEDS - 1);
                    end
                    else
                    begin
                        for (int e = 0; e < NUM_LEDS; e++)
                        begin
                            if (int'(job.led) == e)
                            begin
                                colors_next[e * 3 + int'(OFS_RED)]   = job.red;
                                colors_next[e * 3 + int'(OFS_GREEN)] = job.green;
                                colors_next[e * 3 + int'(OFS_BLUE)]  = job.blue;
                            end
                        end
                        led_next      = job.led;
                        last_led_next = job.led;
                    end
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                prod1_next = color_rd * bright_reg;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                prod2_next = div255(prod1_reg) * limit_sel;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next.controller_sel = led_reg[1];
                    out_next.register_addr  = (led_reg[0] ? BASE_ODD : BASE_EVEN)
                                              + {3'd0, step_reg};
                    out_next.current_code   = div255(prod2_reg);
                    out_next.last_write     = is_last;
                    out_valid_next          = 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (step_reg == STEP_GREEN)
                        begin
                            step_next = STEP_BLUE;
                            led_next  = led_reg + 1'b1;
                        end
                        else
                        begin
                            step_next = step_reg + 1'b1;
                        end
                        state_next = ST_MUL1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bright_reg    <= BRIGHTNESS_RST;
            led_reg       <= '0;
            last_led_reg  <= '0;
            step_reg      <= STEP_BLUE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ENT; i++)
            begin
                colors_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            bright_reg    <= bright_next;
            led_reg       <= led_next;
            last_led_reg  <= last_led_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            colors_reg    <= colors_next;
        end
    end

endmodule

// ===== hdl/rgb_led_current_scaler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_current_scaler_unit
// turns led color and brightness requests into current register writes
// ----------------------------------------------------------------------------
// A set-color request stores one led's red, green and blue levels and yields
// three register writes (blue, red, green); a set-brightness request stores
// the global brightness and rewrites every led, three writes each, led 0
// first. Each code is ((level * brightness) / 255) * max / 255 with the
// channel's max register. Leds 0 and 1 sit on controller 0, leds 2 and 3 on
// controller 1; even leds use register base 0x15, odd leds 0x18. The last
// write of a request carries last_write. In the back end, taking a job from
// the queue is one step, and each write then passes through two registered
// 8x8 multiplies and the output register, which waits while the result side
// holds off pop. The front end keeps taking requests into a two-entry queue
// while the back end works. Color requests for an led index of NUM_LEDS or
// more are dropped at the front. The max registers may only be written while
// the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module rgb_led_current_scaler_unit #(
    parameter int NUM_LEDS = rlcs_pkg::NUM_LEDS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request side
    input  logic                               push,
    output logic                               full,
    input  rlcs_pkg::item_t                    item,
    // write side
    output logic                               empty,
    input  logic                               pop,
    output rlcs_pkg::result_t                  result,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rlcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                         cfg_data
);
    import rlcs_pkg::*;

    limits_t limits_reg;
    logic    q_full;
    logic    q_valid;
    logic    job_push;
    logic    job_pop;
    job_t    front_job;
    job_t    back_job;

    // limits are plain registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.red_limit   <= RED_LIMIT_RST;
            limits_reg.green_limit <= GREEN_LIMIT_RST;
            limits_reg.blue_limit  <= BLUE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RED_LIMIT:   limits_reg.red_limit   <= cfg_data;
                CFG_GREEN_LIMIT: limits_reg.green_limit <= cfg_data;
                CFG_BLUE_LIMIT:  limits_reg.blue_limit  <= cfg_data;
                default:         ;  // unmapped index, ignored
            endcase
        end
    end

    // front: request checking and job building
    rlcs_front #(
        .NUM_LEDS (NUM_LEDS)
    ) u_front (
        .push     (push),
        .item     (item),
        .q_full   (q_full),
        .full     (full),
        .job_push (job_push),
        .job      (front_job)
    );

    // queue between front and back
    rlcs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (front_job),
        .rd_en   (job_pop),
        .rd_job  (back_job),
        .q_full  (q_full),
        .q_valid (q_valid)
    );

    // back: led state, scaling and write output register
    rlcs_back #(
        .NUM_LEDS (NUM_LEDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (q_valid),
        .job_pop   (job_pop),
        .limits    (limits_reg),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// ===== tb/sv/rgb_led_current_scaler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_current_scaler_unit_tb
// self-checking bench for the rgb led current scaler
// ----------------------------------------------------------------------------
// Set-color and set-brightness requests go in through the push/full side.
// Each accepted request runs through a local copy of the scaling logic. That
// copy yields the register writes the block should make. A monitor pops the
// writes and compares each one, field by field, with the oldest predicted
// write. A directed pass covers the level and brightness extremes first.
// Random passes follow, each under a different set of channel limits, with
// random gaps on both sides and one pass with no gaps at all.
// ----------------------------------------------------------------------------
module rgb_led_current_scaler_unit_tb;

    import rlcs_pkg::*;

    localparam int          NUM_LEDS_TB   = NUM_LEDS_DEF;
    localparam int unsigned FULL_SCALE    = 255;
    localparam int          RESET_CYCLES  = 12;
    localparam int          IDLE_PCT      = 19;
    // long enough for a brightness request to pass through the back end
    localparam int          SETTLE_CYCLES = 48;
    localparam int          IDLE_LIMIT    = 3000;
    localparam int          PRINT_LIMIT   = 30;

    // index past the last limit register, written to check it is ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // clock, reset and block inputs, all known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    item_t                req_item  = '0;
    logic                 pop       = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RED_LIMIT;
    logic [7:0]           cfg_data  = '0;

    logic                 full;
    logic                 empty;
    result_t              wr_result;
    logic                 cfg_ready;

    // local copy of the block state, used for prediction
    logic [7:0] red_limit_now   = RED_LIMIT_RST;
    logic [7:0] green_limit_now = GREEN_LIMIT_RST;
    logic [7:0] blue_limit_now  = BLUE_LIMIT_RST;
    logic [7:0] brightness_now  = BRIGHTNESS_RST;
    logic [7:0] led_levels [0:3*NUM_LEDS_TB-1];

    item_t   request_queue  [$];   // requests not yet offered to the block
    result_t pending_writes [$];   // predicted writes, oldest first

    int mismatch_count = 0;
    int idle_count     = 0;
    bit calm           = 1'b0;     // no gaps on either side while set

    rgb_led_current_scaler_unit #(
        .NUM_LEDS (NUM_LEDS_TB)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (req_item),
        .empty     (empty),
        .pop       (pop),
        .result    (wr_result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        foreach (led_levels[i])
        begin
            led_levels[i] = '0;
        end
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // level dimmed by the global brightness, then scaled to the channel limit
    function automatic logic [7:0] scaled_code(input logic [7:0] level,
                                               input logic [7:0] limit);
        int unsigned dimmed;
        int unsigned code;
        dimmed = (32'(level) * 32'(brightness_now)) / FULL_SCALE;
        code   = (dimmed * 32'(limit)) / FULL_SCALE;
        return code[7:0];
    endfunction

    // three writes for one led: blue, red, green at base, base+1, base+2
    function automatic void queue_led_writes(input int led, input bit last_led);
        result_t    wr;
        logic [4:0] base;
        int         e;
        base              = led[0] ? BASE_ODD : BASE_EVEN;
        e                 = led * 3;
        wr.controller_sel = led[1];
        wr.last_write     = 1'b0;
        wr.register_addr  = base + 5'(STEP_BLUE);
        wr.current_code   = scaled_code(led_levels[e + OFS_BLUE], blue_limit_now);
        pending_writes.push_back(wr);
        wr.register_addr  = base + 5'(STEP_RED);
        wr.current_code   = scaled_code(led_levels[e + OFS_RED], red_limit_now);
        pending_writes.push_back(wr);
        // the green write closes the led, and the request if it is the last led
        wr.register_addr  = base + 5'(STEP_GREEN);
        wr.current_code   = scaled_code(led_levels[e + OFS_GREEN], green_limit_now);
        wr.last_write     = last_led;
        pending_writes.push_back(wr);
    endfunction

    function automatic void predict_writes(input item_t it);
        int e;
        if (it.kind == KIND_COLOR)
        begin
            // an led past the count is dropped without any write
            if (int'(it.led_index) < NUM_LEDS_TB)
            begin
                e                         = int'(it.led_index) * 3;
                led_levels[e + OFS_RED]   = it.red_level;
                led_levels[e + OFS_GREEN] = it.green_level;
                led_levels[e + OFS_BLUE]  = it.blue_level;
                queue_led_writes(int'(it.led_index), 1'b1);
            end
        end
        else
        begin
            // levels are kept, so brightness zero only zeroes the written codes
            brightness_now = it.new_brightness;
            for (int led = 0; led < NUM_LEDS_TB; led++)
            begin
                queue_led_writes(led, led == NUM_LEDS_TB - 1);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------

    // a refused request is held until the block takes it
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_writes(req_item);
            end
            if (!(push && full))
            begin
                if (request_queue.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    push     <= 1'b1;
                    req_item <= request_queue.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // write monitor
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("[%0t] write mismatch: %s", $realtime, what);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pending_writes.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected write addr 0x%0h code %0d",
                                            wr_result.register_addr,
                                            wr_result.current_code));
                end
                else
                begin
                    want = pending_writes.pop_front();
                    if (wr_result.controller_sel !== want.controller_sel)
                        flag_mismatch($sformatf("controller_sel got %0d want %0d",
                                                wr_result.controller_sel,
                                                want.controller_sel));
                    if (wr_result.register_addr !== want.register_addr)
                        flag_mismatch($sformatf("register_addr got 0x%0h want 0x%0h",
                                                wr_result.register_addr,
                                                want.register_addr));
                    if (wr_result.current_code !== want.current_code)
                        flag_mismatch($sformatf("current_code got %0d want %0d (addr 0x%0h)",
                                                wr_result.current_code,
                                                want.current_code,
                                                want.register_addr));
                    if (wr_result.last_write !== want.last_write)
                        flag_mismatch($sformatf("last_write got %0d want %0d (addr 0x%0h)",
                                                wr_result.last_write,
                                                want.last_write,
                                                want.register_addr));
                end
            end
            pop <= calm || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            begin
                idle_count <= 0;
            end
            else if (idle_count >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                idle_count <= idle_count + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // called from the clocked stimulus; the block must be idle
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RED_LIMIT:   red_limit_now   = val;
            CFG_GREEN_LIMIT: green_limit_now = val;
            CFG_BLUE_LIMIT:  blue_limit_now  = val;
            default:         ;   // no register behind this index
        endcase
        @(posedge clk);
    endtask

    // fields of the other kind carry junk, the block must ignore them
    task automatic add_color(input int led, input int r, input int g, input int b);
        item_t it;
        it.kind           = KIND_COLOR;
        it.led_index      = 2'(led);
        it.red_level      = 8'(r);
        it.green_level    = 8'(g);
        it.blue_level     = 8'(b);
        it.new_brightness = 8'($urandom);
        request_queue.push_back(it);
    endtask

    task automatic add_brightness(input int level);
        item_t it;
        it.kind           = KIND_BRIGHT;
        it.led_index      = 2'($urandom);
        it.red_level      = 8'($urandom);
        it.green_level    = 8'($urandom);
        it.blue_level     = 8'($urandom);
        it.new_brightness = 8'(level);
        request_queue.push_back(it);
    endtask

    // mostly uniform, with the end points favored
    function automatic int pick_level();
        int roll;
        roll = $urandom_range(7);
        if (roll == 0)
            return 0;
        else if (roll == 1)
            return 255;
        else
            return $urandom_range(255);
    endfunction

    task automatic add_random_requests(input int count);
        repeat (count)
        begin
            if ($urandom_range(99) < 25)
                add_brightness(pick_level());
            else
                add_color($urandom_range(3), pick_level(), pick_level(), pick_level());
        end
    endtask

    // all requests taken, all writes seen, then let the back end settle
    task automatic wait_until_settled();
        while (request_queue.size() != 0 || push || pending_writes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass under the reset limits
        add_color(0, 255, 255, 255);
        add_color(1, 0, 0, 0);
        add_color(2, 255, 0, 128);
        add_color(3, 1, 254, 127);
        add_brightness(255);
        add_brightness(0);
        // stored at brightness zero, must come back on the next brightness
        add_color(1, 200, 100, 50);
        add_brightness(1);
        add_brightness(128);
        add_color(0, 128, 64, 32);
        add_brightness(254);
        add_color(3, 255, 255, 255);
        add_brightness(255);
        wait_until_settled();

        // full-scale limits, plus a write to the unused index
        write_limit(CFG_RED_LIMIT, 8'd255);
        write_limit(CFG_GREEN_LIMIT, 8'd255);
        write_limit(CFG_BLUE_LIMIT, 8'd255);
        write_limit(CFG_UNUSED, 8'h5a);
        add_color(2, 255, 255, 255);
        add_brightness(255);
        add_random_requests(28);
        wait_until_settled();

        // zero limits: every code zero
        write_limit(CFG_RED_LIMIT, 8'd0);
        write_limit(CFG_GREEN_LIMIT, 8'd0);
        write_limit(CFG_BLUE_LIMIT, 8'd0);
        add_random_requests(20);
        wait_until_settled();

        // random limits, back to back with no gaps on either side
        write_limit(CFG_RED_LIMIT, 8'($urandom));
        write_limit(CFG_GREEN_LIMIT, 8'($urandom));
        write_limit(CFG_BLUE_LIMIT, 8'($urandom));
        calm = 1'b1;
        add_random_requests(40);
        wait_until_settled();
        calm = 1'b0;

        // uneven limits near the ends
        write_limit(CFG_RED_LIMIT, 8'd1);
        write_limit(CFG_GREEN_LIMIT, 8'd128);
        write_limit(CFG_BLUE_LIMIT, 8'd254);
        add_random_requests(30);
        wait_until_settled();

        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
